// ===== design/dcvcr_pkg.sv =====
// shared types, constants and the arctangent table of the current regulator
package dcvcr_pkg;

  localparam int CFG_IDX_W     = 4;
  localparam int CORDIC_STEPS  = 30;

  localparam longint Q30_TWO_PI      = 64'sd6746518852;
  localparam longint Q30_PI          = 64'sd3373259426;
  localparam longint Q30_HALF_PI     = 64'sd1686629713;
  localparam longint Q30_CORDIC_GAIN = 64'sd652032874;

  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D        = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_Q        = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEFF   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_GAIN  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_HIGH    = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT_LOW     = 4'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ACT,
    S_MOD,
    S_WRAP,
    S_FOLD,
    S_CORDIC,
    S_SC,
    S_OUT
  } state_t;

  // multiplier micro-ops, issued in this order
  typedef enum logic [3:0] {
    OP_THETA,
    OP_RD1,
    OP_RD2,
    OP_RQ1,
    OP_RQ2,
    OP_CD,
    OP_CQ,
    OP_ID,
    OP_IQ,
    OP_PD1,
    OP_PD2,
    OP_PQ1,
    OP_PQ2,
    OP_DD,
    OP_DQ
  } op_t;

  // truncated q30 arctangent of 2^-i
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'h3243F6A8;
      5'd1:  a = 32'h1DAC6705;
      5'd2:  a = 32'h0FADBAFC;
      5'd3:  a = 32'h07F56EA6;
      5'd4:  a = 32'h03FEAB76;
      5'd5:  a = 32'h01FFD55B;
      5'd6:  a = 32'h00FFFAAA;
      5'd7:  a = 32'h007FFF55;
      5'd8:  a = 32'h003FFFEA;
      5'd9:  a = 32'h001FFFFD;
      5'd10: a = 32'h000FFFFF;
      5'd11: a = 32'h0007FFFF;
      5'd12: a = 32'h0003FFFF;
      5'd13: a = 32'h0001FFFF;
      5'd14: a = 32'h0000FFFF;
      5'd15: a = 32'h00007FFF;
      5'd16: a = 32'h00003FFF;
      5'd17: a = 32'h00001FFF;
      5'd18: a = 32'h00000FFF;
      5'd19: a = 32'h000007FF;
      5'd20: a = 32'h000003FF;
      5'd21: a = 32'h000001FF;
      5'd22: a = 32'h000000FF;
      5'd23: a = 32'h0000007F;
      5'd24: a = 32'h0000003F;
      5'd25: a = 32'h0000001F;
      5'd26: a = 32'h0000000F;
      5'd27: a = 32'h00000008;
      5'd28: a = 32'h00000004;
      5'd29: a = 32'h00000002;
      default: a = 32'h00000000;
    endcase
    return a;
  endfunction

endpackage

// ===== design/dcvcr_if.sv =====
// channel interfaces: control sample in, voltage result out, register writes
interface dcvcr_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] ref_d;
  logic signed [31:0] fdb_d;
  logic signed [31:0] ref_q;
  logic signed [31:0] fdb_q;
  logic signed [31:0] elec_speed;
  logic signed [31:0] pred_d;
  logic signed [31:0] pred_q;

  modport source (output valid, ref_d, fdb_d, ref_q, fdb_q, elec_speed, pred_d, pred_q,
                  input ready);
  modport sink (input valid, ref_d, fdb_d, ref_q, fdb_q, elec_speed, pred_d, pred_q,
                output ready);
endinterface

interface dcvcr_result_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] volt_d;
  logic signed [31:0] volt_q;
  logic signed [31:0] integ_out_d;
  logic signed [31:0] integ_out_q;
  logic signed [31:0] damp_d;
  logic signed [31:0] damp_q;

  modport source (output valid, volt_d, volt_q, integ_out_d, integ_out_q, damp_d, damp_q,
                  input ready);
  modport sink (input valid, volt_d, volt_q, integ_out_d, integ_out_q, damp_d, damp_q,
                output ready);
endinterface

interface dcvcr_cfg_if import dcvcr_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [31:0]          data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== design/damped_complex_vector_current_regulator.sv =====
// damped complex-vector pi current regulator: sequencer, shared multiplier and cordic
//
// channels: sample (sink) takes one control sample per beat, result (source)
// gives one beat of voltage commands, integrators and damping terms per sample,
// cfg (sink) writes the seven gain/limit registers by index and is always ready.
// the block works on one sample at a time; sample.ready is high only while idle.
// from a sample beat to result valid the sequencer works through, in order:
//   the theta product on the shared multiplier,
//   MOD_STEPS steps of compare-subtract for the angle reduction (5 at the
//   default widths), wrap and fold, 30 cordic iterations,
//   scaling, 14 products on the multiplier (S_MUL then S_ACT for each),
//   then the load of the output register.
// the next sample is taken in the cycle after the result is loaded, so the
// block takes no new sample before the current result has been loaded.
// the result sits in an output register; a stalled receiver does not block a
// new sample, but the next result waits until the held beat has been taken.
// reset (rst, synchronous) clears the errors, integrators and sequencer and
// sets the gains to zero and the limits to the full range.
module damped_complex_vector_current_regulator
  import dcvcr_pkg::*;
#(
  parameter int DATA_WIDTH = 32,
  parameter int FRAC_BITS  = 24
) (
  input  logic                clk,
  input  logic                rst,
  dcvcr_sample_if.sink        sample,
  dcvcr_result_if.source      result,
  dcvcr_cfg_if.sink           cfg
);

  localparam int DW        = DATA_WIDTH;
  localparam int ZSH       = 30 - FRAC_BITS;
  localparam int ZW        = DW + ZSH;
  localparam int RW        = (ZW + 1 > 35) ? ZW + 1 : 35;
  localparam int MOD_STEPS = (ZW > 34) ? ZW - 33 : 1;
  localparam int CNT_W     = $clog2((CORDIC_STEPS > MOD_STEPS) ? CORDIC_STEPS : MOD_STEPS);
  localparam int ZCW       = 35;
  localparam int CRW       = 36;
  localparam int PW        = DW + 32;

  localparam logic signed [63:0] SMAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
  localparam logic signed [63:0] SMIN = -SMAX - 64'sd1;

  function automatic logic signed [DW-1:0] sat64(input logic signed [63:0] v);
    logic signed [63:0] r;
    if (v > SMAX) r = SMAX;
    else if (v < SMIN) r = SMIN;
    else r = v;
    return r[DW-1:0];
  endfunction

  function automatic logic signed [DW-1:0] limit(input logic signed [DW-1:0] v,
                                                 input logic signed [DW-1:0] hi,
                                                 input logic signed [DW-1:0] lo);
    logic signed [DW-1:0] r;
    if (v > hi) r = hi;
    else if (v < lo) r = lo;
    else r = v;
    return r;
  endfunction

  // configuration registers
  logic signed [DW-1:0] kd, kq, kdec, kdmp, lim_hi, lim_lo;
  logic [30:0]          sp;

  // state and working registers
  state_t state, state_next;
  op_t    op;
  logic [CNT_W-1:0]      cnt;
  logic signed [DW-1:0]  prev_d, prev_q, integ_d, integ_q;
  logic signed [DW-1:0]  err_d, err_q, we, pd, pq;
  logic signed [DW-1:0]  cosv, sinv, acc, rot_d, rot_q, cor_d, cor_q, prd, prq;
  logic signed [DW-1:0]  vd, vq, dd, dq;
  logic signed [PW-1:0]  prod;
  logic [RW-1:0]         rem;
  logic                  zneg, neg_cos;
  logic signed [ZCW-1:0] cz;
  logic signed [CRW-1:0] cx, cy;
  logic                  res_valid;
  logic signed [DW-1:0]  o_vd, o_vq, o_id, o_iq, o_dd, o_dq;

  // shared multiplier operand select
  logic signed [DW-1:0] mul_a;
  logic signed [31:0]   mul_b;
  logic signed [DW-1:0] m;

  always_comb begin
    mul_a = we;
    mul_b = signed'({1'b0, sp});
    unique case (op)
      OP_THETA: begin mul_a = we;     mul_b = signed'({1'b0, sp}); end
      OP_RD1:   begin mul_a = prev_d; mul_b = 32'(cosv);  end
      OP_RD2:   begin mul_a = prev_q; mul_b = 32'(sinv);  end
      OP_RQ1:   begin mul_a = prev_q; mul_b = 32'(cosv);  end
      OP_RQ2:   begin mul_a = prev_d; mul_b = 32'(sinv);  end
      OP_CD:    begin mul_a = kdec;   mul_b = 32'(rot_d); end
      OP_CQ:    begin mul_a = kdec;   mul_b = 32'(rot_q); end
      OP_ID:    begin mul_a = kd;     mul_b = 32'(cor_d); end
      OP_IQ:    begin mul_a = kq;     mul_b = 32'(cor_q); end
      OP_PD1:   begin mul_a = pd;     mul_b = 32'(cosv);  end
      OP_PD2:   begin mul_a = pq;     mul_b = 32'(sinv);  end
      OP_PQ1:   begin mul_a = pq;     mul_b = 32'(cosv);  end
      OP_PQ2:   begin mul_a = pd;     mul_b = 32'(sinv);  end
      OP_DD:    begin mul_a = kdmp;   mul_b = 32'(prd);   end
      OP_DQ:    begin mul_a = kdmp;   mul_b = 32'(prq);   end
      default:  begin mul_a = we;     mul_b = signed'({1'b0, sp}); end
    endcase
  end

  assign m = sat64(64'(prod) >>> FRAC_BITS);

  // angle reduction helpers
  logic [RW-1:0]         mod_cand;
  logic signed [ZCW-1:0] wrap_r, wrap_fix;
  logic signed [63:0]    th64, thmag;
  logic signed [CRW-1:0] xs, ys, xr;
  logic signed [ZCW-1:0] at;

  always_comb begin
    mod_cand = RW'(Q30_TWO_PI) << cnt;
    wrap_r = ZCW'(rem);
    if (zneg && rem != '0) wrap_r = ZCW'(Q30_TWO_PI) - ZCW'(rem);
    wrap_fix = (wrap_r > ZCW'(Q30_PI)) ? wrap_r - ZCW'(Q30_TWO_PI) : wrap_r;
    th64  = 64'(m);
    thmag = th64[63] ? -th64 : th64;
    xs = cx >>> cnt;
    ys = cy >>> cnt;
    xr = cx >>> ZSH;
    at = ZCW'(atan_q30(5'(cnt)));
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (sample.valid) state_next = S_MUL;
      S_MUL:    state_next = S_ACT;
      S_ACT: begin
        if (op == OP_THETA)   state_next = S_MOD;
        else if (op == OP_DQ) state_next = S_OUT;
        else                  state_next = S_MUL;
      end
      S_MOD:    if (cnt == '0) state_next = S_WRAP;
      S_WRAP:   state_next = S_FOLD;
      S_FOLD:   state_next = S_CORDIC;
      S_CORDIC: if (cnt == CNT_W'(CORDIC_STEPS - 1)) state_next = S_SC;
      S_SC:     state_next = S_MUL;
      S_OUT:    if (!res_valid || result.ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  assign sample.ready = (state == S_IDLE);
  assign cfg.ready    = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      kd     <= '0;
      kq     <= '0;
      kdec   <= '0;
      kdmp   <= '0;
      sp     <= '0;
      lim_hi <= sat64(64'sd2147483647);
      lim_lo <= sat64(-64'sd2147483648);
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_GAIN_D:        kd     <= sat64(64'(signed'(cfg.data)));
        REG_GAIN_Q:        kq     <= sat64(64'(signed'(cfg.data)));
        REG_DECAY_COEFF:   kdec   <= sat64(64'(signed'(cfg.data)));
        REG_DAMPING_GAIN:  kdmp   <= sat64(64'(signed'(cfg.data)));
        REG_SAMPLE_PERIOD: sp     <= cfg.data[30:0];
        REG_LIMIT_HIGH:    lim_hi <= sat64(64'(signed'(cfg.data)));
        REG_LIMIT_LOW:     lim_lo <= sat64(64'(signed'(cfg.data)));
        default: ;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_d    <= '0;
      prev_q    <= '0;
      integ_d   <= '0;
      integ_q   <= '0;
      res_valid <= 1'b0;
      op        <= OP_THETA;
      cnt       <= '0;
    end else begin
      if (state == S_OUT && (!res_valid || result.ready)) res_valid <= 1'b1;
      else if (result.ready)                              res_valid <= 1'b0;
      unique case (state)
        S_IDLE: op <= OP_THETA;
        S_ACT: begin
          if (op == OP_THETA) cnt <= CNT_W'(MOD_STEPS - 1);
          else if (op != OP_DQ) op <= op_t'(op + 4'd1);
          if (op == OP_ID) integ_d <= limit(sat64(64'(integ_d) + 64'(m)), lim_hi, lim_lo);
          if (op == OP_IQ) integ_q <= limit(sat64(64'(integ_q) + 64'(m)), lim_hi, lim_lo);
        end
        S_MOD:    if (cnt != '0) cnt <= cnt - 1'b1;
        S_FOLD:   cnt <= '0;
        S_CORDIC: cnt <= cnt + 1'b1;
        S_SC:     op <= OP_RD1;
        S_OUT: begin
          if (!res_valid || result.ready) begin
            prev_d    <= err_d;
            prev_q    <= err_q;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (sample.valid) begin
          err_d <= sat64(64'(sat64(64'(sample.ref_d))) - 64'(sat64(64'(sample.fdb_d))));
          err_q <= sat64(64'(sat64(64'(sample.ref_q))) - 64'(sat64(64'(sample.fdb_q))));
          we    <= sat64(64'(sample.elec_speed));
          pd    <= sat64(64'(sample.pred_d));
          pq    <= sat64(64'(sample.pred_q));
        end
      end
      S_MUL: prod <= PW'(mul_a) * PW'(mul_b);
      S_ACT: begin
        case (op)
          OP_THETA: begin
            zneg <= th64[63];
            rem  <= RW'(thmag <<< ZSH);
          end
          OP_RD1, OP_RQ1, OP_PD1, OP_PQ1: acc <= m;
          OP_RD2: rot_d <= sat64(64'(acc) + 64'(m));
          OP_RQ2: rot_q <= sat64(64'(acc) - 64'(m));
          OP_CD:  cor_d <= sat64(64'(err_d) - 64'(m));
          OP_CQ:  cor_q <= sat64(64'(err_q) - 64'(m));
          OP_PD2: prd   <= sat64(64'(acc) + 64'(m));
          OP_PQ2: prq   <= sat64(64'(acc) - 64'(m));
          OP_DD: begin
            dd <= m;
            vd <= limit(sat64(64'(integ_d) - 64'(m)), lim_hi, lim_lo);
          end
          OP_DQ: begin
            dq <= m;
            vq <= limit(sat64(64'(integ_q) - 64'(m)), lim_hi, lim_lo);
          end
          default: ;
        endcase
      end
      S_MOD: if (rem >= mod_cand) rem <= rem - mod_cand;
      S_WRAP: cz <= wrap_fix;
      S_FOLD: begin
        cx <= CRW'(Q30_CORDIC_GAIN);
        cy <= '0;
        if (cz > ZCW'(Q30_HALF_PI)) begin
          cz      <= ZCW'(Q30_PI) - cz;
          neg_cos <= 1'b1;
        end else if (cz < -ZCW'(Q30_HALF_PI)) begin
          cz      <= -ZCW'(Q30_PI) - cz;
          neg_cos <= 1'b1;
        end else begin
          neg_cos <= 1'b0;
        end
      end
      S_CORDIC: begin
        if (!cz[ZCW-1]) begin
          cx <= cx - ys;
          cy <= cy + xs;
          cz <= cz - at;
        end else begin
          cx <= cx + ys;
          cy <= cy - xs;
          cz <= cz + at;
        end
      end
      S_SC: begin
        cosv <= sat64(neg_cos ? -64'(xr) : 64'(xr));
        sinv <= sat64(64'(cy >>> ZSH));
      end
      S_OUT: begin
        if (!res_valid || result.ready) begin
          o_vd <= vd;
          o_vq <= vq;
          o_id <= integ_d;
          o_iq <= integ_q;
          o_dd <= dd;
          o_dq <= dq;
        end
      end
      default: ;
    endcase
  end

  assign result.valid       = res_valid;
  assign result.volt_d      = 32'(o_vd);
  assign result.volt_q      = 32'(o_vq);
  assign result.integ_out_d = 32'(o_id);
  assign result.integ_out_q = 32'(o_iq);
  assign result.damp_d      = 32'(o_dd);
  assign result.damp_q      = 32'(o_dq);

  // checks
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !sample.ready)
    else $error("sample taken while busy");

  a_accept_starts_theta: assert property (@(posedge clk) disable iff (rst)
    (sample.valid && sample.ready) |=> (state == S_MUL && op == OP_THETA))
    else $error("sample beat did not start the theta product");

  a_cordic_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_CORDIC) |-> (cnt <= CNT_W'(CORDIC_STEPS - 1)))
    else $error("cordic step count out of range");

  a_integ_in_limits: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && lim_lo <= lim_hi) |-> (integ_d <= lim_hi && integ_d >= lim_lo
      && vq <= lim_hi && vq >= lim_lo))
    else $error("integrator or command outside the limits");

endmodule

// ===== sim/tb_damped_complex_vector_current_regulator.sv =====
// self-checking testbench of the damped complex-vector current regulator
`timescale 1ns / 100ps

module tb_damped_complex_vector_current_regulator
  import dcvcr_pkg::*;
();

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_RANDOM       = 700;

  typedef struct packed {
    logic signed [31:0] ref_d, fdb_d, ref_q, fdb_q, elec_speed, pred_d, pred_q;
  } sample_t;

  typedef struct packed {
    logic signed [31:0] volt_d, volt_q, integ_d, integ_q, damp_d, damp_q;
  } volt_t;

  typedef struct packed {
    logic                 is_cfg;
    logic [CFG_IDX_W-1:0] index;
    logic [31:0]          data;
    sample_t              smp;
  } job_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dcvcr_sample_if sample_ch ();
  dcvcr_result_if result_ch ();
  dcvcr_cfg_if    cfg_ch ();

  damped_complex_vector_current_regulator u_dut (
    .clk    (clk),
    .rst    (rst),
    .sample (sample_ch.sink),
    .result (result_ch.source),
    .cfg    (cfg_ch.sink)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor state
  longint k_gain_d, k_gain_q, k_decay, k_damp, k_period, k_lim_hi, k_lim_lo;
  longint err_prev_d, err_prev_q, acc_d, acc_q;

  job_t   job_q[$];
  volt_t  volt_expected_q[$];
  int     errors = 0;
  int     beats_done = 0;
  int     stalled = 0;
  bit     stim_done = 0;

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint qmul(longint a, longint b);
    return sat32((a * b) >>> 24);
  endfunction

  function automatic longint clamp_out(longint v);
    if (v > k_lim_hi) return k_lim_hi;
    if (v < k_lim_lo) return k_lim_lo;
    return v;
  endfunction

  task automatic sin_cos(input longint theta, output longint s, output longint c);
    longint z, x, y, nx;
    bit flip;
    z = theta * 64;
    x = Q30_CORDIC_GAIN;
    y = 0;
    flip = 0;
    z = z % Q30_TWO_PI;
    if (z < 0) z += Q30_TWO_PI;
    if (z > Q30_PI) z -= Q30_TWO_PI;
    if (z > Q30_HALF_PI) begin
      z = Q30_PI - z;
      flip = 1;
    end else if (z < -Q30_HALF_PI) begin
      z = -Q30_PI - z;
      flip = 1;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      if (z >= 0) begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        z -= longint'(atan_q30(i[4:0]));
      end else begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        z += longint'(atan_q30(i[4:0]));
      end
      x = nx;
    end
    x = x >>> 6;
    y = y >>> 6;
    c = sat32(flip ? -x : x);
    s = sat32(y);
  endtask

  task automatic write_reg_model(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    case (idx)
      REG_GAIN_D:        k_gain_d = longint'(signed'(d));
      REG_GAIN_Q:        k_gain_q = longint'(signed'(d));
      REG_DECAY_COEFF:   k_decay  = longint'(signed'(d));
      REG_DAMPING_GAIN:  k_damp   = longint'(signed'(d));
      REG_SAMPLE_PERIOD: k_period = longint'({1'b0, d[30:0]});
      REG_LIMIT_HIGH:    k_lim_hi = longint'(signed'(d));
      REG_LIMIT_LOW:     k_lim_lo = longint'(signed'(d));
      default: ;
    endcase
  endtask

  task automatic regulate(input sample_t x);
    longint s, c, ed, eq, rd, rq, cd, cq, pd, pq, dd, dq;
    volt_t r;
    sin_cos(qmul(x.elec_speed, k_period), s, c);
    ed = sat32(longint'(x.ref_d) - x.fdb_d);
    eq = sat32(longint'(x.ref_q) - x.fdb_q);
    rd = sat32(qmul(err_prev_d, c) + qmul(err_prev_q, s));
    rq = sat32(qmul(err_prev_q, c) - qmul(err_prev_d, s));
    cd = sat32(ed - qmul(k_decay, rd));
    cq = sat32(eq - qmul(k_decay, rq));
    acc_d = clamp_out(sat32(acc_d + qmul(k_gain_d, cd)));
    acc_q = clamp_out(sat32(acc_q + qmul(k_gain_q, cq)));
    pd = sat32(qmul(x.pred_d, c) + qmul(x.pred_q, s));
    pq = sat32(qmul(x.pred_q, c) - qmul(x.pred_d, s));
    dd = qmul(k_damp, pd);
    dq = qmul(k_damp, pq);
    r.volt_d  = 32'(clamp_out(sat32(acc_d - dd)));
    r.volt_q  = 32'(clamp_out(sat32(acc_q - dq)));
    r.integ_d = 32'(acc_d);
    r.integ_q = 32'(acc_q);
    r.damp_d  = 32'(dd);
    r.damp_q  = 32'(dq);
    err_prev_d = ed;
    err_prev_q = eq;
    volt_expected_q.push_back(r);
  endtask

  // driver: register writes wait until every expected beat has come back
  int gap_in = 0;
  int drain = 0;
  always @(posedge clk) begin
    if (rst) begin
      sample_ch.valid <= 1'b0;
      cfg_ch.valid    <= 1'b0;
      gap_in          <= 0;
      drain           <= 0;
    end else begin
      logic s_next, c_next;
      job_t j_done;
      s_next = sample_ch.valid && !sample_ch.ready;
      c_next = 1'b0;
      if (sample_ch.valid && sample_ch.ready) begin
        j_done = job_q.pop_front();
        regulate(j_done.smp);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        write_reg_model(cfg_ch.index, cfg_ch.data);
        void'(job_q.pop_front());
      end
      if (volt_expected_q.size() != 0) drain <= 30;
      else if (drain > 0) drain <= drain - 1;
      if (!s_next && !(cfg_ch.valid && !cfg_ch.ready)) begin
        if (gap_in > 0) begin
          gap_in <= gap_in - 1;
        end else if (job_q.size() != 0 && !(sample_ch.valid && sample_ch.ready)
                     && !(cfg_ch.valid && cfg_ch.ready)) begin
          if (job_q[0].is_cfg) begin
            if (volt_expected_q.size() == 0 && drain == 0) begin
              c_next = 1'b1;
              cfg_ch.index <= job_q[0].index;
              cfg_ch.data  <= job_q[0].data;
            end
          end else begin
            s_next = 1'b1;
            {sample_ch.ref_d, sample_ch.fdb_d, sample_ch.ref_q, sample_ch.fdb_q,
             sample_ch.elec_speed, sample_ch.pred_d, sample_ch.pred_q} <= job_q[0].smp;
            gap_in <= ($urandom_range(0, 9) < 6) ? 0 :
                      ($urandom_range(0, 9) < 8) ? $urandom_range(1, 5)
                                                : $urandom_range(20, 120);
          end
        end
      end else if (cfg_ch.valid && !cfg_ch.ready) begin
        c_next = 1'b1;
      end
      sample_ch.valid <= s_next;
      cfg_ch.valid    <= c_next;
    end
  end

  // monitor with random backpressure
  int stall_out = 0;
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_out       <= 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        volt_t exp_v;
        beats_done <= beats_done + 1;
        if (volt_expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          errors++;
        end else begin
          exp_v = volt_expected_q.pop_front();
          if (result_ch.volt_d !== exp_v.volt_d) begin
            $error("volt_d exp %0d got %0d", exp_v.volt_d, result_ch.volt_d); errors++;
          end
          if (result_ch.volt_q !== exp_v.volt_q) begin
            $error("volt_q exp %0d got %0d", exp_v.volt_q, result_ch.volt_q); errors++;
          end
          if (result_ch.integ_out_d !== exp_v.integ_d) begin
            $error("integ_out_d exp %0d got %0d", exp_v.integ_d, result_ch.integ_out_d);
            errors++;
          end
          if (result_ch.integ_out_q !== exp_v.integ_q) begin
            $error("integ_out_q exp %0d got %0d", exp_v.integ_q, result_ch.integ_out_q);
            errors++;
          end
          if (result_ch.damp_d !== exp_v.damp_d) begin
            $error("damp_d exp %0d got %0d", exp_v.damp_d, result_ch.damp_d); errors++;
          end
          if (result_ch.damp_q !== exp_v.damp_q) begin
            $error("damp_q exp %0d got %0d", exp_v.damp_q, result_ch.damp_q); errors++;
          end
        end
      end
      // mostly ready, short stalls and now and then a long one
      if (stall_out > 0) begin
        stall_out       <= stall_out - 1;
        result_ch.ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 10) begin
        result_ch.ready <= 1'b0;
        stall_out       <= ($urandom_range(0, 9) < 8) ? $urandom_range(0, 4)
                                                      : $urandom_range(50, 300);
      end else begin
        result_ch.ready <= 1'b1;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (rst || (sample_ch.valid && sample_ch.ready) || (cfg_ch.valid && cfg_ch.ready)
        || (result_ch.valid && result_ch.ready)) begin
      stalled <= 0;
    end else begin
      stalled <= stalled + 1;
      if (stalled >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h7FFFFFFF;
      1: return 32'h80000000;
      2: return 32'h0;
      3: return $urandom_range(0, 1) ? 32'hFFFFFFFF : 32'h1;
      4, 5: return $urandom;
      default: return {{8{$urandom_range(0, 1) ? 1'b1 : 1'b0}}, 24'($urandom)};
    endcase
  endfunction

  function automatic sample_t rand_sample();
    sample_t x;
    x = {rand_word(), rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
         rand_word()};
    return x;
  endfunction

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] d);
    job_t j;
    j = '0;
    j.is_cfg = 1'b1;
    j.index = idx;
    j.data = d;
    job_q.push_back(j);
  endtask

  task automatic add_sample(input sample_t x);
    job_t j;
    j = '0;
    j.smp = x;
    job_q.push_back(j);
  endtask

  task automatic add_random_config();
    add_cfg(REG_GAIN_D, rand_word());
    add_cfg(REG_GAIN_Q, rand_word());
    add_cfg(REG_DECAY_COEFF, rand_word());
    add_cfg(REG_DAMPING_GAIN, $urandom_range(0, 3) == 0 ? 32'h0 : rand_word());
    add_cfg(REG_SAMPLE_PERIOD, rand_word());
    if ($urandom_range(0, 2) == 0) begin
      add_cfg(REG_LIMIT_HIGH, 32'h7FFFFFFF);
      add_cfg(REG_LIMIT_LOW, 32'h80000000);
    end else begin
      add_cfg(REG_LIMIT_HIGH, rand_word());
      add_cfg(REG_LIMIT_LOW, rand_word());
    end
  endtask

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.ref_d = '0; sample_ch.fdb_d = '0; sample_ch.ref_q = '0;
    sample_ch.fdb_q = '0; sample_ch.elec_speed = '0;
    sample_ch.pred_d = '0; sample_ch.pred_q = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    result_ch.ready = 1'b0;
    k_gain_d = 0; k_gain_q = 0; k_decay = 0; k_damp = 0; k_period = 0;
    k_lim_hi = 64'sd2147483647; k_lim_lo = -64'sd2147483648;
    err_prev_d = 0; err_prev_q = 0; acc_d = 0; acc_q = 0;

    // directed: reset settings, then plain pi, damping, extremes, crossed limits
    add_sample({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000});
    add_cfg(REG_GAIN_D, 32'h01000000);
    add_cfg(REG_GAIN_Q, 32'h00800000);
    add_cfg(REG_DECAY_COEFF, 32'h00F00000);
    add_cfg(REG_DAMPING_GAIN, 32'h0);
    add_cfg(REG_SAMPLE_PERIOD, 32'h00000A7C);
    add_sample({32'sh01000000, 32'sh0, 32'sh02000000, 32'sh00800000,
                32'sh7FFFFFFF, 32'sh0, 32'sh0});
    add_sample({32'sh01000000, 32'sh0, 32'sh02000000, 32'sh00800000,
                32'sh80000000, 32'sh0, 32'sh0});
    add_sample({32'sh7FFFFFFF, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                32'sh0, 32'sh0, 32'sh0});
    add_cfg(REG_DAMPING_GAIN, 32'h7FFFFFFF);
    add_cfg(REG_SAMPLE_PERIOD, 32'hFFFFFFFF);
    add_sample({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh03243F6A, 32'sh7FFFFFFF, 32'sh80000000});
    add_sample({32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'shFCDBC096, 32'sh80000000, 32'sh7FFFFFFF});
    add_cfg(REG_DAMPING_GAIN, 32'h80000000);
    add_cfg(REG_GAIN_D, 32'h80000000);
    add_cfg(REG_GAIN_Q, 32'h7FFFFFFF);
    add_cfg(REG_DECAY_COEFF, 32'h80000000);
    add_sample({32'sh12345678, 32'shEDCBA988, 32'sh0, 32'sh1, 32'sh1, 32'sh01000000, 32'sh0});
    add_cfg(REG_LIMIT_HIGH, 32'h00100000);
    add_cfg(REG_LIMIT_LOW, 32'hFFF00000);
    add_sample({32'sh7FFFFFFF, 32'sh0, 32'sh80000000, 32'sh0, 32'sh0, 32'sh0, 32'sh0});
    add_cfg(REG_LIMIT_LOW, 32'h00200000); // crossed limits
    add_sample({32'sh0, 32'sh7FFFFFFF, 32'sh0, 32'sh80000000, 32'sh0, 32'sh00400000, 32'sh0});
    add_cfg(REG_SAMPLE_PERIOD, 32'h0);
    add_cfg(4'd9, 32'hDEADBEEF); // unmapped index
    add_sample({32'sh1, 32'shFFFFFFFF, 32'shFFFFFFFF, 32'sh1, 32'sh55555555,
                32'shAAAAAAAA, 32'sh55555555});

    // random phases of 50 samples under new settings
    for (int p = 0; p < N_RANDOM / 50; p++) begin
      add_random_config();
      for (int i = 0; i < 50; i++) add_sample(rand_sample());
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    wait (job_q.size() == 0);
    wait (volt_expected_q.size() == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/dcvcr_pkg.sv
design/dcvcr_if.sv
design/damped_complex_vector_current_regulator.sv
sim/tb_damped_complex_vector_current_regulator.sv
